/* src/gated_gravity_force_top_assert.svh */
// assertion macros for the gravity force block
`ifndef GATED_GRAVITY_FORCE_TOP_ASSERT_SVH
`define GATED_GRAVITY_FORCE_TOP_ASSERT_SVH

// same-cycle implication
`define GGF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GGF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ggf_pkg.sv */
// types, constants and latencies shared by the gravity force block
package ggf_pkg;

  localparam int unsigned MIN_DISTANCE_DEF = 5;
  localparam int unsigned MAX_DISTANCE_DEF = 25;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned FRONT_LAT = 3;
  localparam int unsigned SQ_BITS   = 24;
  localparam int unsigned SQ_STEPS  = 4;
  localparam int unsigned SQ_STAGES = SQ_BITS / SQ_STEPS;
  localparam int unsigned DIV_BITS  = 32;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DIV_STAGES = DIV_BITS / DIV_STEPS;
  localparam int unsigned DIV_LAT   = DIV_STAGES + 1;
  localparam int unsigned TOTAL_LAT = FRONT_LAT + SQ_STAGES + 2 + DIV_LAT + 1;

  typedef enum logic [2:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_FR = 3'd2,
    REG_G  = 3'd3,
    REG_M  = 3'd4
  } ggf_reg_e;

  typedef struct packed {
    logic signed [15:0] particle_x;
    logic signed [15:0] particle_y;
    logic [9:0]         particle_radius;
    logic [7:0]         particle_mass;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic               inside_field;
  } force_t;

  typedef struct packed {
    logic [11:0] attractor_x;
    logic [11:0] attractor_y;
    logic [12:0] field_radius;
    logic [7:0]  gravity_constant;
    logic [7:0]  attractor_mass;
  } cfg_t;

  typedef struct packed {
    logic [23:0] c2;
    logic [39:0] prodx;
    logic [39:0] prody;
    logic        negx;
    logic        negy;
    logic        in_field;
    logic        zero;
  } sq_side_t;

  typedef struct packed {
    logic negx;
    logic negy;
    logic in_field;
    logic zero;
  } flags_t;

endpackage

/* src/ggf_regs.sv */
// configuration register file on the apb-style port
module ggf_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ggf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ggf_pkg::DATA_W-1:0]   pwdata,
  output logic [ggf_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output ggf_pkg::cfg_t                cfg_o
);
  import ggf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  ggf_reg_e idx;
  logic     wr;

  assign idx    = ggf_reg_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_AX:  cfg_d.attractor_x      = pwdata[11:0];
        REG_AY:  cfg_d.attractor_y      = pwdata[11:0];
        REG_FR:  cfg_d.field_radius     = pwdata[12:0];
        REG_G:   cfg_d.gravity_constant = pwdata[7:0];
        REG_M:   cfg_d.attractor_mass   = pwdata[7:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AX:  prdata = {20'b0, cfg_q.attractor_x};
      REG_AY:  prdata = {20'b0, cfg_q.attractor_y};
      REG_FR:  prdata = {19'b0, cfg_q.field_radius};
      REG_G:   prdata = {24'b0, cfg_q.gravity_constant};
      REG_M:   prdata = {24'b0, cfg_q.attractor_mass};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attractor_x      <= 12'd0;
      cfg_q.attractor_y      <= 12'd0;
      cfg_q.field_radius     <= 13'd0;
      cfg_q.gravity_constant <= 8'd5;
      cfg_q.attractor_mass   <= 8'd20;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* src/ggf_front.sv */
// separation, squared distance, field test, clamp and numerator products
module ggf_front #(
  parameter int unsigned MIN_DISTANCE = ggf_pkg::MIN_DISTANCE_DEF,
  parameter int unsigned MAX_DISTANCE = ggf_pkg::MAX_DISTANCE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ggf_pkg::particle_t  particle_i,
  input  ggf_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  output logic [31:0]         d2_o,
  output ggf_pkg::sq_side_t   side_o
);
  import ggf_pkg::*;

  localparam logic [23:0] LO2 = 24'(MIN_DISTANCE * MIN_DISTANCE);
  localparam logic [23:0] HI2 = 24'(MAX_DISTANCE * MAX_DISTANCE);

  // stage 1
  logic [16:0] dx_w, dy_w;
  logic        v1_q, negx1_q, negy1_q;
  logic [15:0] absx1_q, absy1_q;
  logic [13:0] reach1_q;
  logic [15:0] gm1_q;
  logic [7:0]  pm1_q;

  assign dx_w = {5'b0, cfg_i.attractor_x}
              - {particle_i.particle_x[15], particle_i.particle_x};
  assign dy_w = {5'b0, cfg_i.attractor_y}
              - {particle_i.particle_y[15], particle_i.particle_y};

  // stage 2
  logic        v2_q, negx2_q, negy2_q;
  logic [15:0] absx2_q, absy2_q;
  logic [31:0] sqx2_q, sqy2_q;
  logic [27:0] reach2_q;
  logic [23:0] s2_q;

  // stage 3
  logic [32:0] sum_w;
  logic [31:0] d2_w;
  logic [23:0] c2_w;
  logic        v3_q;
  logic [31:0] d2_q;
  sq_side_t    side_q;

  assign sum_w = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  assign d2_w  = sum_w[31:0];

  always_comb begin
    if (d2_w > {8'b0, HI2}) begin
      c2_w = HI2;
    end else if (d2_w < {8'b0, LO2}) begin
      c2_w = LO2;
    end else begin
      c2_w = d2_w[23:0];
    end
    if (c2_w == 24'd0) begin
      c2_w = 24'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    negx1_q  <= dx_w[16];
    negy1_q  <= dy_w[16];
    absx1_q  <= dx_w[16] ? 16'(~dx_w + 17'd1) : dx_w[15:0];
    absy1_q  <= dy_w[16] ? 16'(~dy_w + 17'd1) : dy_w[15:0];
    reach1_q <= {1'b0, cfg_i.field_radius} + {4'b0, particle_i.particle_radius};
    gm1_q    <= cfg_i.gravity_constant * cfg_i.attractor_mass;
    pm1_q    <= particle_i.particle_mass;

    negx2_q  <= negx1_q;
    negy2_q  <= negy1_q;
    absx2_q  <= absx1_q;
    absy2_q  <= absy1_q;
    sqx2_q   <= absx1_q * absx1_q;
    sqy2_q   <= absy1_q * absy1_q;
    reach2_q <= reach1_q * reach1_q;
    s2_q     <= gm1_q * pm1_q;

    d2_q            <= d2_w;
    side_q.c2       <= c2_w;
    side_q.prodx    <= absx2_q * s2_q;
    side_q.prody    <= absy2_q * s2_q;
    side_q.negx     <= negx2_q;
    side_q.negy     <= negy2_q;
    side_q.in_field <= d2_w <= {4'b0, reach2_q};
    side_q.zero     <= d2_w == 32'd0;
  end

  assign valid_o = v3_q;
  assign d2_o    = d2_q;
  assign side_o  = side_q;

endmodule

/* src/ggf_sqrt.sv */
// pipelined digit-by-digit square root of d2 in q.8
module ggf_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        d2_i,
  input  ggf_pkg::sq_side_t  side_i,
  output logic               valid_o,
  output logic [23:0]        dq_o,
  output ggf_pkg::sq_side_t  side_o
);
  import ggf_pkg::*;

  logic [SQ_STAGES-1:0] v_q;
  logic [25:0]          rem_q  [SQ_STAGES];
  logic [23:0]          root_q [SQ_STAGES];
  logic [47:0]          rad_q  [SQ_STAGES];
  sq_side_t             side_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_st
    logic [25:0] rem_in, rem_nx;
    logic [23:0] root_in, root_nx;
    logic [47:0] rad_in;
    logic        v_in;
    sq_side_t    side_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {d2_i, 16'b0};
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [27:0] t;
      logic [27:0] trial;
      rem_nx  = rem_in;
      root_nx = root_in;
      for (int k = 0; k < SQ_STEPS; k++) begin
        t     = {rem_nx, rad_in[47-2*k -: 2]};
        trial = {2'b0, root_nx, 2'b01};
        if (t >= trial) begin
          rem_nx  = 26'(t - trial);
          root_nx = {root_nx[22:0], 1'b1};
        end else begin
          rem_nx  = 26'(t);
          root_nx = {root_nx[22:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_nx;
      root_q[s] <= root_nx;
      rad_q[s]  <= {rad_in[47-2*SQ_STEPS:0], {(2*SQ_STEPS){1'b0}}};
      side_q[s] <= side_in;
    end
  end

  assign valid_o = v_q[SQ_STAGES-1];
  assign dq_o    = root_q[SQ_STAGES-1];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule

/* src/ggf_div.sv */
// pipelined restoring divider, 32 quotient bits with overflow flag
module ggf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [56:0] num_i,
  input  logic [47:0] den_i,
  output logic        valid_o,
  output logic [31:0] quo_o,
  output logic        ovf_o
);
  import ggf_pkg::*;

  logic                  v0_q, ovf0_q;
  logic [47:0]           rem0_q, den0_q;
  logic [DIV_BITS-1:0]   low0_q;

  logic [DIV_STAGES-1:0] v_q, ovf_q;
  logic [47:0]           rem_q [DIV_STAGES];
  logic [47:0]           den_q [DIV_STAGES];
  logic [DIV_BITS-1:0]   low_q [DIV_STAGES];
  logic [DIV_BITS-1:0]   quo_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf0_q <= {23'b0, num_i[56:32]} >= den_i;
    rem0_q <= {23'b0, num_i[56:32]};
    den0_q <= den_i;
    low0_q <= num_i[31:0];
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic                v_in, ovf_in;
    logic [47:0]         rem_in, den_in, rem_nx;
    logic [DIV_BITS-1:0] low_in, quo_in, low_nx, quo_nx;

    if (s == 0) begin : g_first
      assign v_in   = v0_q;
      assign ovf_in = ovf0_q;
      assign rem_in = rem0_q;
      assign den_in = den0_q;
      assign low_in = low0_q;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign ovf_in = ovf_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      logic [48:0] t;
      rem_nx = rem_in;
      low_nx = low_in;
      quo_nx = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        t      = {rem_nx, low_nx[DIV_BITS-1]};
        low_nx = {low_nx[DIV_BITS-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          rem_nx = 48'(t - {1'b0, den_in});
          quo_nx = {quo_nx[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_nx = t[47:0];
          quo_nx = {quo_nx[DIV_BITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      ovf_q[s] <= ovf_in;
      rem_q[s] <= rem_nx;
      den_q[s] <= den_in;
      low_q[s] <= low_nx;
      quo_q[s] <= quo_nx;
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign ovf_o   = ovf_q[DIV_STAGES-1];

endmodule

/* src/gated_gravity_force_top.sv */
// top level of the gated point-mass gravity force pipeline
//
//  channel   handshake                          payload
//  particle  start high, busy low               particle_i (particle_t)
//  force     done_o high for one cycle          result_o (force_t)
//  config    psel, penable, pwrite, pready      paddr, pwdata / prdata
//
// one particle word per cycle
// the pipeline is the front end (3), the square root pipeline (6, four digits per stage),
// two product stages, the divider lanes (17, two quotient bits per stage) and one output stage
// busy stays low; all pipeline registers advance every cycle
// reset clears the valid bits and loads the register reset values
module gated_gravity_force_top #(
  parameter int unsigned MIN_DISTANCE = ggf_pkg::MIN_DISTANCE_DEF,
  parameter int unsigned MAX_DISTANCE = ggf_pkg::MAX_DISTANCE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ggf_pkg::particle_t          particle_i,
  output logic                        done_o,
  output ggf_pkg::force_t             result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ggf_pkg::ADDR_W-1:0]  paddr,
  input  logic [ggf_pkg::DATA_W-1:0]  pwdata,
  output logic [ggf_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import ggf_pkg::*;

  function automatic logic [31:0] sat_force(logic [31:0] q, logic ovf, logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(~q + 32'd1);
    end else begin
      r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
    end
    return r;
  endfunction

  cfg_t     cfg;
  logic     front_v, sq_v;
  logic [31:0] d2;
  logic [23:0] dq;
  sq_side_t front_side, sq_side;

  assign busy = 1'b0;

  ggf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ggf_front #(
    .MIN_DISTANCE (MIN_DISTANCE),
    .MAX_DISTANCE (MAX_DISTANCE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .particle_i (particle_i),
    .cfg_i      (cfg),
    .valid_o    (front_v),
    .d2_o       (d2),
    .side_o     (front_side)
  );

  ggf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_v),
    .d2_i    (d2),
    .side_i  (front_side),
    .valid_o (sq_v),
    .dq_o    (dq),
    .side_o  (sq_side)
  );

  // denominator and rounded numerators
  logic        t1_v_q, t2_v_q;
  logic [47:0] den1_q, den2_q;
  logic [39:0] prodx1_q, prody1_q;
  flags_t      fl1_q, fl2_q;
  logic [56:0] numx2_q, numy2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
    end else begin
      t1_v_q <= sq_v;
      t2_v_q <= t1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    den1_q         <= dq * sq_side.c2;
    prodx1_q       <= sq_side.prodx;
    prody1_q       <= sq_side.prody;
    fl1_q.negx     <= sq_side.negx;
    fl1_q.negy     <= sq_side.negy;
    fl1_q.in_field <= sq_side.in_field;
    fl1_q.zero     <= sq_side.zero;

    den2_q  <= den1_q;
    numx2_q <= {1'b0, prodx1_q, 16'b0} + {10'b0, den1_q[47:1]};
    numy2_q <= {1'b0, prody1_q, 16'b0} + {10'b0, den1_q[47:1]};
    fl2_q   <= fl1_q;
  end

  logic        dvx, dvy, ovfx, ovfy;
  logic [31:0] qx, qy;

  ggf_div u_divx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t2_v_q),
    .num_i   (numx2_q),
    .den_i   (den2_q),
    .valid_o (dvx),
    .quo_o   (qx),
    .ovf_o   (ovfx)
  );

  ggf_div u_divy (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t2_v_q),
    .num_i   (numy2_q),
    .den_i   (den2_q),
    .valid_o (dvy),
    .quo_o   (qy),
    .ovf_o   (ovfy)
  );

  flags_t fl_q [DIV_LAT];

  for (genvar s = 0; s < DIV_LAT; s++) begin : g_fl
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) fl_q[s] <= fl2_q;
    end else begin : g_next
      always_ff @(posedge clk_i) fl_q[s] <= fl_q[s-1];
    end
  end

  // output word
  flags_t fl;
  logic   zero_force;
  logic   done_q;
  force_t result_q, result_d;

  assign fl         = fl_q[DIV_LAT-1];
  assign zero_force = !fl.in_field || fl.zero;

  always_comb begin
    result_d.inside_field = fl.in_field;
    result_d.force_x = zero_force ? 32'sd0 : $signed(sat_force(qx, ovfx, fl.negx));
    result_d.force_y = zero_force ? 32'sd0 : $signed(sat_force(qy, ovfy, fl.negy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvx && dvy;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`include "gated_gravity_force_top_assert.svh"

  `GGF_ASSERT_IMP(a_done_latency, done_o, $past(start && !busy, TOTAL_LAT), "result without start")
  `GGF_ASSERT_IMP(a_outside_zero, done_o && !result_o.inside_field,
                  result_o.force_x == 32'sd0 && result_o.force_y == 32'sd0, "force outside field")
  `GGF_ASSERT_NXT(a_cfg_write, psel && penable && pwrite && ggf_reg_e'(paddr[4:2]) == REG_AX,
                  cfg.attractor_x == $past(pwdata[11:0]), "attractor x not written")

endmodule

/* test/ggf_force_checker.sv */
// force checker: tracks the register writes, predicts each force word and compares results
`timescale 1ns / 100ps

module ggf_force_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic                        busy,
  input  ggf_pkg::particle_t          particle_i,
  input  logic                        done_o,
  input  ggf_pkg::force_t             result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ggf_pkg::ADDR_W-1:0]  paddr,
  input  logic [ggf_pkg::DATA_W-1:0]  pwdata,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 force_count_o,
  output int unsigned                 inside_count_o
);
  import ggf_pkg::*;

  localparam longint unsigned MIN_D = MIN_DISTANCE_DEF;
  localparam longint unsigned MAX_D = MAX_DISTANCE_DEF;

  cfg_t   regs_q;
  force_t pending_forces[$];

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] scaled_component(input longint delta,
                                                   input longint unsigned s,
                                                   input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (delta < 0) ? longint'(-delta) : longint'(delta);
    q   = (mag * s * 64'd65536 + den / 2) / den;
    if (delta < 0) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return 32'(64'd0 - q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return q[31:0];
  endfunction

  function automatic force_t force_for_particle(input particle_t p, input cfg_t c);
    force_t          f;
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned reach;
    longint unsigned c2;
    longint unsigned dq;
    longint unsigned s;
    f  = '0;
    dx = longint'(c.attractor_x) - longint'(p.particle_x);
    dy = longint'(c.attractor_y) - longint'(p.particle_y);
    d2 = dx * dx + dy * dy;
    reach = longint'(c.field_radius) + longint'(p.particle_radius);
    if (d2 > reach * reach) return f;
    f.inside_field = 1'b1;
    if (d2 == 0) return f;
    if (d2 > MAX_D * MAX_D) c2 = MAX_D * MAX_D;
    else if (d2 < MIN_D * MIN_D) c2 = MIN_D * MIN_D;
    else c2 = d2;
    if (c2 == 0) c2 = 1;
    dq = int_sqrt(d2 << 16);
    s  = longint'(c.gravity_constant) * longint'(c.attractor_mass) *
         longint'(p.particle_mass);
    f.force_x = scaled_component(dx, s, dq * c2);
    f.force_y = scaled_component(dy, s, dq * c2);
    return f;
  endfunction

  assign pending_o = pending_forces.size();

  always @(posedge clk_i or negedge rst_ni) begin
    force_t      want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      regs_q.attractor_x      <= '0;
      regs_q.attractor_y      <= '0;
      regs_q.field_radius     <= '0;
      regs_q.gravity_constant <= 8'd5;
      regs_q.attractor_mass   <= 8'd20;
      pending_forces.delete();
      fail_count_o   <= 0;
      force_count_o  <= 0;
      inside_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_AX: regs_q.attractor_x      <= pwdata[11:0];
          REG_AY: regs_q.attractor_y      <= pwdata[11:0];
          REG_FR: regs_q.field_radius     <= pwdata[12:0];
          REG_G:  regs_q.gravity_constant <= pwdata[7:0];
          REG_M:  regs_q.attractor_mass   <= pwdata[7:0];
          default: ;
        endcase
      end
      if (done_o) begin
        force_count_o <= force_count_o + 1;
        if (result_o.inside_field) inside_count_o <= inside_count_o + 1;
        if (pending_forces.size() == 0) begin
          $error("force word with no particle waiting");
          errs++;
        end else begin
          want = pending_forces.pop_front();
          if (result_o.force_x !== want.force_x) begin
            $error("force_x expected %0d got %0d", want.force_x, result_o.force_x);
            errs++;
          end
          if (result_o.force_y !== want.force_y) begin
            $error("force_y expected %0d got %0d", want.force_y, result_o.force_y);
            errs++;
          end
          if (result_o.inside_field !== want.inside_field) begin
            $error("inside_field expected %0b got %0b", want.inside_field,
                   result_o.inside_field);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      if (start && !busy) pending_forces.push_back(force_for_particle(particle_i, regs_q));
    end
  end

endmodule

/* test/tb_gated_gravity_force_top.sv */
// testbench top: drives particles and register writes into the gravity force block
`timescale 1ns / 100ps

module tb_gated_gravity_force_top;
  import ggf_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  particle_t particle_i = '0;
  logic done_o;
  force_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned force_count;
  int unsigned inside_count;
  int unsigned stall_cycles = 0;
  int unsigned sent = 0;
  cfg_t cur_cfg;

  always #2 clk_i = ~clk_i;

  gated_gravity_force_top dut (
    .clk_i, .rst_ni, .start, .busy, .particle_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ggf_force_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .particle_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .force_count_o(force_count), .inside_count_o(inside_count)
  );

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_gated_gravity_force_top: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // drain, wait out the pipeline, then load all registers
  task automatic load_config(input cfg_t c);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 2) @(posedge clk_i);
    // upper bits set to check that only the register width is kept
    reg_write(REG_AX, {$urandom} << 12 | c.attractor_x);
    reg_write(REG_AY, {$urandom} << 12 | c.attractor_y);
    reg_write(REG_FR, {$urandom} << 13 | c.field_radius);
    reg_write(REG_G,  {$urandom} << 8 | c.gravity_constant);
    reg_write(REG_M,  {$urandom} << 8 | c.attractor_mass);
    // unused index, must be ignored
    reg_write(3'($urandom_range(5, 7)), $urandom);
    cur_cfg = c;
  endtask

  task automatic send_particle(input particle_t p);
    int unsigned gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    particle_i <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  function automatic particle_t mk(input int x, input int y, input int r, input int m);
    particle_t p;
    p.particle_x      = 16'(x);
    p.particle_y      = 16'(y);
    p.particle_radius = 10'(r);
    p.particle_mass   = 8'(m);
    return p;
  endfunction

  function automatic particle_t near_particle(input cfg_t c);
    particle_t p;
    int lim;
    p   = mk(0, 0, $urandom_range(0, 1023), $urandom_range(0, 255));
    lim = int'(c.field_radius) + int'(p.particle_radius);
    if (lim > 40 && $urandom_range(0, 1) == 0) lim = 40;
    p.particle_x = 16'(int'(c.attractor_x) + $urandom_range(0, 2 * lim) - lim);
    p.particle_y = 16'(int'(c.attractor_y) + $urandom_range(0, 2 * lim) - lim);
    return p;
  endfunction

  initial begin
    cfg_t c;
    particle_t p;
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values first
    for (n = 0; n < 4; n++) send_particle(mk($urandom_range(0, 3), $urandom_range(0, 3), 5, 200));

    c = '{attractor_x: 12'd100, attractor_y: 12'd200, field_radius: 13'd50,
          gravity_constant: 8'd5, attractor_mass: 8'd20};
    load_config(c);
    send_particle(mk(100, 200, 0, 255));
    send_particle(mk(103, 200, 0, 255));
    send_particle(mk(97, 196, 0, 128));
    send_particle(mk(110, 200, 0, 10));
    send_particle(mk(100, 240, 0, 255));
    send_particle(mk(100, 260, 0, 1));
    send_particle(mk(100, 260, 10, 1));
    send_particle(mk(-32768, -32768, 1023, 255));
    send_particle(mk(32767, 32767, 1023, 0));
    send_particle(mk(90, 210, 0, 77));

    c = '{attractor_x: 12'd4095, attractor_y: 12'd4095, field_radius: 13'd8191,
          gravity_constant: 8'd255, attractor_mass: 8'd255};
    load_config(c);
    send_particle(mk(4094, 4095, 0, 255));
    send_particle(mk(4096, 4095, 0, 255));
    send_particle(mk(4095, 4094, 0, 255));
    send_particle(mk(4095, 4096, 0, 255));
    send_particle(mk(-32768, 32767, 1023, 255));
    send_particle(mk(32767, -32768, 1023, 255));
    send_particle(mk(-4096, -4096, 1023, 255));

    c = '0;
    load_config(c);
    send_particle(mk(0, 0, 0, 255));
    send_particle(mk(3, 4, 5, 255));
    send_particle(mk(-30, 40, 1023, 255));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: c = '{12'd2048, 12'd2048, 13'd8191, 8'd255, 8'd255};
        1: c = '{12'd0, 12'd0, 13'd0, 8'd0, 8'd0};
        2: c = '{12'd4095, 12'd0, 13'd30, 8'd1, 8'd1};
        default: begin
          c.attractor_x      = 12'($urandom);
          c.attractor_y      = 12'($urandom);
          c.field_radius     = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 60)) :
                               13'($urandom);
          c.gravity_constant = 8'($urandom);
          c.attractor_mass   = 8'($urandom);
        end
      endcase
      load_config(c);
      for (n = 0; n < 130; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          p = particle_t'({$urandom, $urandom});
        end else begin
          p = near_particle(cur_cfg);
        end
        send_particle(p);
        if (n == 65 && ph == 4) begin
          start <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 4) @(posedge clk_i);
    $display("sent %0d particles over 11 register settings", sent);
    $display("checked %0d force words, %0d inside the field", force_count, inside_count);
    if (fail_count == 0) begin
      $display("tb_gated_gravity_force_top: clean");
    end else begin
      $display("tb_gated_gravity_force_top: errors");
    end
    $finish;
  end

endmodule
